[rtl/strt_pkg.sv]
// ----------------------------------------------------------------------------
// strt_pkg
// Types and constants shared by the stimulus trial response tracker.
// ----------------------------------------------------------------------------
package strt_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned SID_W    = 16;
    localparam int unsigned CNT8_W   = 8;
    localparam int unsigned SPIKE_W  = 16;
    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned OUT_DATA_W = 104;
    localparam int unsigned CFG_ADDR_W = 2;

    // Stimuli needed to complete a pattern when the expected count is unknown
    localparam logic [CNT8_W-1:0] LEGACY_STIMS = 8'd4;

    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_USE_DATASET = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_POST_WINDOW = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LATE_WINDOW = 2'd3;

    // Classified tick handed from the front to the back
    typedef struct packed {
        logic [TIME_W-1:0] time_now;
        logic              stim_rise;
        logic              spike_rise;
        logic [SID_W-1:0]  sid;
        logic [CNT8_W-1:0] exp_stims;
        logic [CNT8_W-1:0] label;
        logic [TIME_W-1:0] late_limit;   // saturated time_now + late_window
    } t_item;

    // Closed trial record
    typedef struct packed {
        logic [TIME_W-1:0]  close_time;
        logic               deadline_valid;
        logic [TIME_W-1:0]  deadline;
        logic [CNT8_W-1:0]  n_stims;
        logic [CNT8_W-1:0]  class_label;
        logic               late;
        logic               fired;
        logic [SPIKE_W-1:0] n_spikes;
    } t_rec;

    typedef struct packed {
        logic              use_dataset;
        logic [TIME_W-1:0] post_window;
        logic [TIME_W-1:0] late_window;
    } t_cfg;

endpackage

[rtl/strt_front.sv]
// ----------------------------------------------------------------------------
// strt_front
// Detects stimulus and spike edges and precomputes the close limit per tick.
// ----------------------------------------------------------------------------
module strt_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_enable,
    input  logic [strt_pkg::TIME_W-1:0]    i_late_window,
    input  logic                           i_in_valid,
    input  logic [strt_pkg::IN_DATA_W-1:0] i_in_data,
    input  logic                           i_q_ready,
    output logic                           o_in_ready,
    output logic                           o_q_push,
    output strt_pkg::t_item                o_q_item
);
    import strt_pkg::*;

    logic              r_prev_stim;
    logic              r_prev_spike;
    logic              accept;
    logic [TIME_W-1:0] now;
    logic              stim;
    logic              spike;
    logic [TIME_W:0]   late_sum;

    assign now   = i_in_data[31:0];
    assign stim  = i_in_data[32];
    assign spike = i_in_data[33];

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;
    assign late_sum   = {1'b0, now} + {1'b0, i_late_window};

    always_comb begin
        o_q_item.time_now   = now;
        o_q_item.stim_rise  = !r_prev_stim && stim;
        o_q_item.spike_rise = !r_prev_spike && spike;
        o_q_item.sid        = i_in_data[49:34];
        o_q_item.exp_stims  = i_in_data[57:50];
        o_q_item.label      = i_in_data[65:58];
        o_q_item.late_limit = late_sum[TIME_W] ? '1 : late_sum[TIME_W-1:0];
    end

    // Disabled ticks are taken and dropped without touching the edge history
    assign o_q_push = accept && i_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_stim  <= 1'b0;
            r_prev_spike <= 1'b0;
        end else if (o_q_push) begin
            r_prev_stim  <= stim;
            r_prev_spike <= spike;
        end
    end

endmodule

[rtl/strt_queue.sv]
// ----------------------------------------------------------------------------
// strt_queue
// Two-entry queue of classified ticks between front and back.
// ----------------------------------------------------------------------------
module strt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  strt_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_ready,
    output logic            o_valid,
    output strt_pkg::t_item o_item
);
    import strt_pkg::*;

    t_item       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[rtl/strt_back.sv]
// ----------------------------------------------------------------------------
// strt_back
// Trial state update, one tick per cycle unless stalled; registered result.
// ----------------------------------------------------------------------------
module strt_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_use_dataset,
    input  logic [strt_pkg::TIME_W-1:0] i_post_window,
    input  logic                        i_q_valid,
    input  strt_pkg::t_item             i_q_item,
    output logic                        o_q_pop,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output strt_pkg::t_rec              o_out_rec
);
    import strt_pkg::*;

    typedef struct packed {
        logic               open;
        logic               pdone;
        logic [SID_W-1:0]   sample;
        logic [CNT8_W-1:0]  expct;
        logic [CNT8_W-1:0]  cls;
        logic [CNT8_W-1:0]  stims;
        logic [SPIKE_W-1:0] spikes;
        logic               fired;
        logic               late;
        logic [TIME_W-1:0]  last;
        logic [TIME_W-1:0]  obs_end;
        logic               oset;
    } t_trial;

    t_trial r_st;
    t_trial n_st;
    t_rec   r_rec;
    t_rec   n_rec;
    logic   r_out_valid;
    logic   emit;

    function automatic t_rec f_capture(t_trial s, logic [TIME_W-1:0] now);
        t_rec r;
        r.n_spikes       = s.spikes;
        r.fired          = s.fired;
        r.late           = s.late;
        r.class_label    = s.cls;
        r.n_stims        = s.stims;
        r.deadline       = s.oset ? s.obs_end : '0;
        r.deadline_valid = s.oset;
        r.close_time     = now;
        return r;
    endfunction

    // Class label survives a close; everything else returns to zero
    function automatic t_trial f_clear(t_trial s);
        t_trial c;
        c        = '0;
        c.cls    = s.cls;
        return c;
    endfunction

    function automatic t_trial f_done(t_trial s, t_item it);
        t_trial c;
        logic   complete;
        c        = s;
        complete = (s.expct != '0) ? (s.stims >= s.expct) : (s.stims >= LEGACY_STIMS);
        if (complete) begin
            c.pdone = 1'b1;
            if (!s.oset) begin
                c.obs_end = it.late_limit;
                c.oset    = 1'b1;
            end
        end
        return c;
    endfunction

    function automatic t_trial f_begin(t_trial s, t_item it, logic use_ds);
        t_trial c;
        c         = s;
        c.open    = 1'b1;
        c.pdone   = 1'b0;
        c.oset    = 1'b0;
        c.obs_end = '0;
        c.sample  = it.sid;
        c.expct   = use_ds ? it.exp_stims : '0;
        c.cls     = it.label;
        c.fired   = 1'b0;
        c.late    = 1'b0;
        c.last    = it.time_now;
        c.stims   = 8'd1;
        c.spikes  = '0;
        return f_done(c, it);
    endfunction

    function automatic t_trial f_append(t_trial s, t_item it);
        t_trial c;
        c = s;
        if (s.stims != '1) begin
            c.stims = s.stims + 8'd1;
        end
        c.last = it.time_now;
        return f_done(c, it);
    endfunction

    function automatic t_trial f_spike(t_trial s, t_item it, logic [TIME_W-1:0] pw);
        t_trial          c;
        logic [TIME_W:0] lim;
        c   = s;
        lim = {1'b0, s.last} + {1'b0, pw};
        if (s.spikes != '1) begin
            c.spikes = s.spikes + 16'd1;
        end
        // Spikes before the last stimulus are counted but not classified
        if (s.pdone && (it.time_now >= s.last)) begin
            if ({1'b0, it.time_now} <= lim) begin
                c.fired = 1'b1;
            end else if (!s.fired) begin
                c.late = 1'b1;
            end
        end
        return c;
    endfunction

    always_comb begin
        t_trial s;
        s     = r_st;
        emit  = 1'b0;
        n_rec = r_rec;
        if (s.open && i_use_dataset && (s.sample != i_q_item.sid)
            && !i_q_item.stim_rise) begin
            n_rec = f_capture(s, i_q_item.time_now);
            emit  = 1'b1;
            s     = f_clear(s);
        end
        if (i_q_item.stim_rise) begin
            if (!s.open) begin
                s = f_begin(s, i_q_item, i_use_dataset);
            end else if (!s.pdone) begin
                s = f_append(s, i_q_item);
            end else begin
                n_rec = f_capture(s, i_q_item.time_now);
                emit  = 1'b1;
                s     = f_begin(f_clear(s), i_q_item, i_use_dataset);
            end
        end
        if (s.open) begin
            if (i_q_item.spike_rise) begin
                s = f_spike(s, i_q_item, i_post_window);
            end
            if (!emit && s.oset && (i_q_item.time_now >= s.obs_end)) begin
                n_rec = f_capture(s, i_q_item.time_now);
                emit  = 1'b1;
                s     = f_clear(s);
            end
        end
        n_st = s;
    end

    // Advance unless a new record would overwrite one still waiting
    assign o_q_pop = i_q_valid && (!emit || !r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_st <= n_st;
            end
            if (o_q_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && emit) begin
            r_rec <= n_rec;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rec   = r_rec;

endmodule

[rtl/stimulus_trial_response_tracker.sv]
// ----------------------------------------------------------------------------
// stimulus_trial_response_tracker
// Tracks stimulus trials and the neuron response, one tick per item.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries one tick per item. Master stream m_axis
//   carries one record per closed trial; a tick yields at most one record.
//   The config port writes a register when i_cfg_we is high; write only
//   while the block is idle.
// Throughput: one item per cycle while no record stalls the back. The front
//   takes a tick whenever the two-entry queue has room; the back clears one
//   queued tick per cycle, its combinational state update sets the rate.
// Path: the queue entry is written at the edge that takes a tick; the back
//   then updates its state and loads the record into the output register
//   when it pops that tick, which a stall can hold back.
// Stall: while m_axis waits with a record, ticks that make no record still
//   pass; a tick that would make one holds in the queue, and when the queue
//   fills s_axis_tready drops.
// Reset: synchronous, active low; clears all trial state, the edge history
//   and the queue, and loads the register defaults (enabled, dataset mode,
//   post window 500000, late window 1500000).
// ----------------------------------------------------------------------------
module stimulus_trial_response_tracker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tdata: time_now[31:0], stim_level[32], spike_level[33], sample[49:34],
    //        expected count[57:50], class[65:58], zero fill
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [strt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tdata: spikes[15:0], fired[16], late[17], class_label[25:18],
    //        stims[33:26], deadline[65:34], deadline_valid[66],
    //        close_time[98:67], zero fill
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [strt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [strt_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [strt_pkg::TIME_W-1:0]     i_cfg_wdata
);
    import strt_pkg::*;

    logic  r_enable;
    t_cfg  r_cfg;
    logic  q_ready;
    logic  q_push;
    t_item q_in;
    logic  q_pop;
    logic  q_valid;
    t_item q_out;
    t_rec  rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable          <= 1'b1;
            r_cfg.use_dataset <= 1'b1;
            r_cfg.post_window <= 32'd500000;
            r_cfg.late_window <= 32'd1500000;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ENABLE:      r_enable          <= i_cfg_wdata[0];
                CFG_USE_DATASET: r_cfg.use_dataset <= i_cfg_wdata[0];
                CFG_POST_WINDOW: r_cfg.post_window <= i_cfg_wdata;
                CFG_LATE_WINDOW: r_cfg.late_window <= i_cfg_wdata;
                default:         r_enable          <= r_enable;
            endcase
        end
    end

    strt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_enable      (r_enable),
        .i_late_window (r_cfg.late_window),
        .i_in_valid    (s_axis_tvalid),
        .i_in_data     (s_axis_tdata),
        .i_q_ready     (q_ready),
        .o_in_ready    (s_axis_tready),
        .o_q_push      (q_push),
        .o_q_item      (q_in)
    );

    strt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    strt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_use_dataset (r_cfg.use_dataset),
        .i_post_window (r_cfg.post_window),
        .i_q_valid     (q_valid),
        .i_q_item      (q_out),
        .o_q_pop       (q_pop),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_rec     (rec)
    );

    assign m_axis_tdata = {5'd0, rec.close_time, rec.deadline_valid, rec.deadline,
                           rec.n_stims, rec.class_label, rec.late, rec.fired,
                           rec.n_spikes};

endmodule

[verif/stimulus_trial_response_tracker_chk.sv]
// ----------------------------------------------------------------------------
// stimulus_trial_response_tracker_chk
// Watches the tick and record streams of the trial tracker, mirrors its trial
// state from every accepted tick, and compares each record field by field
// with the oldest predicted record.
// ----------------------------------------------------------------------------
module stimulus_trial_response_tracker_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [strt_pkg::IN_DATA_W-1:0]  i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [strt_pkg::OUT_DATA_W-1:0] i_out_data,
    input  logic                            i_cfg_we,
    input  logic [strt_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [strt_pkg::TIME_W-1:0]     i_cfg_wdata,
    output int                              o_fail_count,
    output int                              o_pending
);
    import strt_pkg::*;

    localparam logic [TIME_W-1:0] DEF_POST = 32'd500000;
    localparam logic [TIME_W-1:0] DEF_LATE = 32'd1500000;

    typedef struct packed {
        logic [SPIKE_W-1:0] n_spikes;
        logic               fired;
        logic               late;
        logic [CNT8_W-1:0]  class_label;
        logic [CNT8_W-1:0]  n_stims;
        logic [TIME_W-1:0]  deadline;
        logic               deadline_valid;
        logic [TIME_W-1:0]  close_time;
    } t_trial_rec;

    t_trial_rec expected_recs[$];

    // register mirror
    logic              en_on, ds_on;
    logic [TIME_W-1:0] post_span, late_span;

    // trial mirror
    logic               stim_was, spike_was, trial_live, pattern_full;
    logic [SID_W-1:0]   live_sample;
    logic [CNT8_W-1:0]  live_expect, live_class, stim_tally;
    logic [SPIKE_W-1:0] spike_tally;
    logic               hit_timely, hit_late, watch_armed;
    logic [TIME_W-1:0]  last_stim_t, watch_until;
    bit                 spike_claimed;

    function automatic logic [TIME_W-1:0] sat_sum32(input logic [TIME_W-1:0] a,
                                                     input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? '1 : s[TIME_W-1:0];
    endfunction

    function automatic bit pattern_is_full();
        if (live_expect != '0)
            return stim_tally >= live_expect;
        return stim_tally >= LEGACY_STIMS;
    endfunction

    function automatic void arm_watch();
        if (pattern_is_full()) begin
            pattern_full = 1'b1;
            if (!watch_armed) begin
                watch_until = sat_sum32(last_stim_t, late_span);
                watch_armed = 1'b1;
            end
        end
    endfunction

    function automatic void clear_live();
        trial_live   = 1'b0;
        pattern_full = 1'b0;
        live_sample  = '0;
        live_expect  = '0;
        stim_tally   = '0;
        spike_tally  = '0;
        hit_timely   = 1'b0;
        hit_late     = 1'b0;
        last_stim_t  = '0;
        watch_until  = '0;
        watch_armed  = 1'b0;
    endfunction

    function automatic void emit_record(input logic [TIME_W-1:0] now);
        t_trial_rec r;
        r.n_spikes       = spike_tally;
        r.fired          = hit_timely;
        r.late           = hit_late;
        r.class_label    = live_class;
        r.n_stims        = stim_tally;
        r.deadline       = watch_armed ? watch_until : '0;
        r.deadline_valid = watch_armed;
        r.close_time     = now;
        expected_recs.insert(expected_recs.size(), r);
        clear_live();
    endfunction

    function automatic void open_trial(input logic [TIME_W-1:0] now,
                                       input logic [SID_W-1:0] sid,
                                       input logic [CNT8_W-1:0] ex,
                                       input logic [CNT8_W-1:0] cl);
        trial_live   = 1'b1;
        pattern_full = 1'b0;
        watch_armed  = 1'b0;
        watch_until  = '0;
        live_sample  = sid;
        live_expect  = ds_on ? ex : '0;
        live_class   = cl;
        hit_timely   = 1'b0;
        hit_late     = 1'b0;
        last_stim_t  = now;
        stim_tally   = 8'd1;
        spike_tally  = '0;
        arm_watch();
    endfunction

    function automatic void add_stim(input logic [TIME_W-1:0] now);
        if (stim_tally != '1)
            stim_tally = stim_tally + 8'd1;
        last_stim_t = now;
        arm_watch();
    endfunction

    function automatic void claim_spike(input logic [TIME_W-1:0] now);
        if (!trial_live || spike_claimed)
            return;
        if (spike_tally != '1)
            spike_tally = spike_tally + 16'd1;
        spike_claimed = 1'b1;
        // spikes before the pattern completes, or earlier than its last stimulus,
        // are counted only
        if (!pattern_full || now < last_stim_t)
            return;
        if ({1'b0, now} <= {1'b0, last_stim_t} + {1'b0, post_span})
            hit_timely = 1'b1;
        else if (!hit_timely && !hit_late)
            hit_late = 1'b1;
    endfunction

    function automatic void predict_tick(input logic [IN_DATA_W-1:0] d);
        logic [TIME_W-1:0] now;
        logic              stim, spike, stim_rise, spike_rise;
        logic [SID_W-1:0]  sid;
        logic [CNT8_W-1:0] ex, cl;
        bit                closed;
        now   = d[31:0];
        stim  = d[32];
        spike = d[33];
        sid   = d[49:34];
        ex    = d[57:50];
        cl    = d[65:58];
        if (!en_on)
            return;
        stim_rise     = !stim_was && stim;
        spike_rise    = !spike_was && spike;
        stim_was      = stim;
        spike_was     = spike;
        spike_claimed = 1'b0;
        closed        = 1'b0;

        if (trial_live && ds_on && live_sample != sid && !stim_rise) begin
            emit_record(now);
            closed = 1'b1;
        end
        if (stim_rise) begin
            if (!trial_live) begin
                open_trial(now, sid, ex, cl);
            end else if (!pattern_full) begin
                add_stim(now);
            end else begin
                emit_record(now);
                closed = 1'b1;
                open_trial(now, sid, ex, cl);
            end
            if (spike_rise)
                claim_spike(now);
        end
        if (trial_live) begin
            if (spike_rise && !spike_claimed)
                claim_spike(now);
            if (pattern_full && !watch_armed) begin
                watch_until = sat_sum32(last_stim_t, late_span);
                watch_armed = 1'b1;
            end
            // a trial opened by a closing stimulus waits for the next tick
            if (!closed && watch_armed && now >= watch_until)
                emit_record(now);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("chk: %0t %s got %h want %h", $time, what, got, want);
        o_fail_count = o_fail_count + 1;
    endtask

    always @(posedge i_clk) begin : track
        t_trial_rec got, want;
        if (!i_rst_n) begin
            en_on     = 1'b1;
            ds_on     = 1'b1;
            post_span = DEF_POST;
            late_span = DEF_LATE;
            stim_was  = 1'b0;
            spike_was = 1'b0;
            live_class = '0;
            clear_live();
            expected_recs.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.n_spikes       = i_out_data[15:0];
                got.fired          = i_out_data[16];
                got.late           = i_out_data[17];
                got.class_label    = i_out_data[25:18];
                got.n_stims        = i_out_data[33:26];
                got.deadline       = i_out_data[65:34];
                got.deadline_valid = i_out_data[66];
                got.close_time     = i_out_data[98:67];
                if (i_out_data[OUT_DATA_W-1:99] !== '0)
                    report_mismatch("zero fill", 32'(i_out_data[OUT_DATA_W-1:99]), 32'd0);
                if (expected_recs.size() == 0) begin
                    report_mismatch("record with none pending", got.close_time, 32'd0);
                end else begin
                    want = expected_recs.pop_front();
                    if (got.n_spikes !== want.n_spikes)
                        report_mismatch("spikes", 32'(got.n_spikes), 32'(want.n_spikes));
                    if (got.fired !== want.fired)
                        report_mismatch("fired", 32'(got.fired), 32'(want.fired));
                    if (got.late !== want.late)
                        report_mismatch("late", 32'(got.late), 32'(want.late));
                    if (got.class_label !== want.class_label)
                        report_mismatch("class_label", 32'(got.class_label),
                                        32'(want.class_label));
                    if (got.n_stims !== want.n_stims)
                        report_mismatch("stims", 32'(got.n_stims), 32'(want.n_stims));
                    if (got.deadline !== want.deadline)
                        report_mismatch("deadline", got.deadline, want.deadline);
                    if (got.deadline_valid !== want.deadline_valid)
                        report_mismatch("deadline_valid", 32'(got.deadline_valid),
                                        32'(want.deadline_valid));
                    if (got.close_time !== want.close_time)
                        report_mismatch("close_time", got.close_time, want.close_time);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_ENABLE:      en_on     = i_cfg_wdata[0];
                    CFG_USE_DATASET: ds_on     = i_cfg_wdata[0];
                    CFG_POST_WINDOW: post_span = i_cfg_wdata;
                    CFG_LATE_WINDOW: late_span = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_tick(i_in_data);
        end
        o_pending = expected_recs.size();
    end

endmodule

[verif/stimulus_trial_response_tracker_tb.sv]
// ----------------------------------------------------------------------------
// stimulus_trial_response_tracker_tb
// Drives stimulus/spike tick streams into the trial tracker: a directed set of
// trials, then random trial-shaped sequences with noise under several window
// and mode settings, including extremes and a full-length pattern. Sender gaps
// and receiver stalls are random; the checker module predicts every record.
// ----------------------------------------------------------------------------
module stimulus_trial_response_tracker_tb;
    import strt_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = CFG_ENABLE;
    logic [TIME_W-1:0]     i_cfg_wdata   = '0;

    int fail_total;
    int recs_waiting;

    logic [TIME_W-1:0] now_tick    = '0;
    logic              spike_lvl   = 1'b0;
    logic [SID_W-1:0]  cur_sid     = '0;
    logic [CNT8_W-1:0] cur_expect  = '0;
    logic [CNT8_W-1:0] cur_class   = '0;
    int                step_max    = 4;
    bit                gaps_on     = 1'b1;
    bit                dataset_on  = 1'b1;
    int                burst_left  = 0;
    int                phase_items = 0;
    int                cycle_count = 0;
    int                ready_left  = 0;
    int                ready_mode  = 0;

    always #5 i_clk = ~i_clk;

    stimulus_trial_response_tracker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    stimulus_trial_response_tracker_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_total),
        .o_pending    (recs_waiting)
    );

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // record sink: long ready stretches, short and long stalls
    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode    = $urandom_range(0, 3);
            m_axis_tready = (ready_mode == 0 || ready_mode == 3);
            case (ready_mode)
                0:       ready_left = $urandom_range(20, 200);
                1:       ready_left = $urandom_range(1, 3);
                2:       ready_left = $urandom_range(5, 30);
                default: ready_left = $urandom_range(1, 8);
            endcase
        end
        ready_left = ready_left - 1;
    end

    // called and returns at a falling edge
    task automatic send_tick(input logic [TIME_W-1:0] t, input logic stim,
                             input logic spike, input logic [SID_W-1:0] sid,
                             input logic [CNT8_W-1:0] ex, input logic [CNT8_W-1:0] cl);
        int gap;
        if (burst_left == 0) begin
            if (gaps_on && $urandom_range(0, 3) != 0) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25)
                                                  : $urandom_range(1, 4);
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left    = burst_left - 1;
        s_axis_tdata  = {6'b0, cl, ex, sid, spike, stim, t};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic push_tick(input logic stim, input logic spike);
        case ($urandom_range(0, 99))
            0:       now_tick = now_tick - $urandom_range(0, 4 * step_max + 4);
            1:       now_tick = '1;
            default: now_tick = now_tick + $urandom_range(0, step_max);
        endcase
        spike_lvl = spike;
        send_tick(now_tick, stim, spike, cur_sid, cur_expect, cur_class);
        phase_items = phase_items + 1;
    endtask

    function automatic logic roll_spike();
        return ($urandom_range(0, 2) == 0) ? ~spike_lvl : spike_lvl;
    endfunction

    // one sample: optional lead-in, stimulus pulses, then a quiet tail
    task automatic run_trial();
        int need, n_stims, hold;
        if ($urandom_range(0, 3) != 0)
            cur_sid = 16'($urandom);
        case ($urandom_range(0, 9))
            0:       cur_expect = '0;
            1:       cur_expect = 8'($urandom);
            default: cur_expect = 8'($urandom_range(1, 5));
        endcase
        cur_class = 8'($urandom);
        need = int'((dataset_on && cur_expect != '0) ? cur_expect : LEGACY_STIMS);
        n_stims = need;
        case ($urandom_range(0, 5))
            0:       n_stims = need - 1;
            1:       n_stims = need + 1;
            default: ;
        endcase
        if (n_stims > 8)
            n_stims = $urandom_range(1, 8);
        if (n_stims < 1)
            n_stims = 1;
        if ($urandom_range(0, 1) == 0)
            push_tick(1'b0, roll_spike());
        for (int k = 0; k < n_stims; k++) begin
            hold = $urandom_range(1, 2);
            repeat (hold) push_tick(1'b1, roll_spike());
            hold = $urandom_range(1, 3);
            repeat (hold) push_tick(1'b0, roll_spike());
        end
        hold = $urandom_range(0, 15);
        repeat (hold) push_tick(1'b0, roll_spike());
    endtask

    task automatic run_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            if ($urandom_range(0, 2) == 0)
                cur_sid = 16'($urandom);
            cur_expect = 8'($urandom);
            cur_class  = 8'($urandom);
            push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_for_records();
        s_axis_tvalid = 1'b0;
        burst_left    = 0;
        while (recs_waiting != 0) @(negedge i_clk);
    endtask

    // drain, then let ticks that make no record clear the pipeline
    task automatic settle();
        wait_for_records();
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [TIME_W-1:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic configure(input bit dataset, input logic [TIME_W-1:0] post,
                             input logic [TIME_W-1:0] late);
        settle();
        write_reg(CFG_USE_DATASET, {31'b0, dataset});
        write_reg(CFG_POST_WINDOW, post);
        write_reg(CFG_LATE_WINDOW, late);
        dataset_on = dataset;
    endtask

    task automatic run_phase(input int n_items, input int smax);
        step_max    = smax;
        phase_items = 0;
        while (phase_items < n_items) begin
            if ($urandom_range(0, 59) == 0)
                wait_for_records();
            if ($urandom_range(0, 6) == 0)
                run_noise();
            else
                run_trial();
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // default windows: timely fire, watch close, late spike,
        // close-and-reopen, sample change, saturated deadline, time going back
        send_tick(32'd0,        1'b0, 1'b0, 16'd1, 8'd2, 8'd0);
        send_tick(32'd10,       1'b1, 1'b0, 16'd1, 8'd2, 8'hFF);
        send_tick(32'd20,       1'b0, 1'b1, 16'd1, 8'd2, 8'hFF);
        send_tick(32'd30,       1'b1, 1'b0, 16'd1, 8'd2, 8'hFF);
        send_tick(32'd100,      1'b0, 1'b1, 16'd1, 8'd2, 8'hFF);
        send_tick(32'd200,      1'b0, 1'b0, 16'd1, 8'd2, 8'hFF);
        send_tick(32'd600000,   1'b0, 1'b1, 16'd1, 8'd2, 8'hFF);
        send_tick(32'd1500030,  1'b0, 1'b0, 16'd1, 8'd2, 8'hFF);
        send_tick(32'd1500040,  1'b1, 1'b0, 16'hFFFF, 8'd1, 8'hA5);
        send_tick(32'd1500050,  1'b0, 1'b0, 16'hFFFF, 8'd1, 8'hA5);
        send_tick(32'd2100000,  1'b0, 1'b1, 16'hFFFF, 8'd1, 8'hA5);
        send_tick(32'd2100001,  1'b1, 1'b0, 16'hFFFF, 8'd1, 8'h5A);
        send_tick(32'd5000000,  1'b0, 1'b0, 16'hFFFF, 8'd1, 8'h5A);
        send_tick(32'd5000010,  1'b1, 1'b1, 16'd7, 8'd0, 8'd3);
        send_tick(32'd5000020,  1'b0, 1'b0, 16'd8, 8'd0, 8'd3);
        send_tick(32'hFFFF0000, 1'b1, 1'b0, 16'd9, 8'd1, 8'd4);
        send_tick(32'hFFFF0001, 1'b0, 1'b0, 16'd9, 8'd1, 8'd4);
        send_tick(32'd100,      1'b0, 1'b1, 16'd9, 8'd1, 8'd4);
        send_tick(32'hFFFFFFFF, 1'b0, 1'b0, 16'd9, 8'd1, 8'd4);
        send_tick(32'hFFFFFFFF, 1'b0, 1'b1, 16'd9, 8'd1, 8'd4);
        send_tick(32'hFFFFFFFF, 1'b0, 1'b0, 16'd9, 8'd1, 8'd4);

        configure(1'b1, 32'd40, 32'd120);
        run_phase(200, 10);

        configure(1'b0, 32'd0, 32'd1);
        now_tick = $urandom;
        run_phase(150, 3);

        configure(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF);
        now_tick = 32'hFFFF_F000;
        run_phase(120, 300);

        // disabled: ticks pass through with no effect
        settle();
        write_reg(CFG_ENABLE, 32'd0);
        run_phase(50, 5);
        settle();
        write_reg(CFG_ENABLE, 32'd1);

        configure(1'b0, $urandom_range(0, 60), $urandom_range(1, 200));
        run_phase(150, 8);

        configure(1'b1, $urandom_range(0, 60), $urandom_range(1, 200));
        run_phase(200, 8);

        // longest dataset pattern: 255 stimuli, closed by a sample change
        configure(1'b1, 32'd100, 32'd1000);
        gaps_on    = 1'b0;
        step_max   = 1;
        cur_sid    = 16'hA5A5;
        cur_expect = 8'hFF;
        cur_class  = 8'($urandom);
        push_tick(1'b0, 1'b0);
        repeat (255) begin
            push_tick(1'b1, 1'b0);
            push_tick(1'b0, 1'b0);
        end
        cur_sid = 16'h0F0F;
        push_tick(1'b0, 1'b0);
        gaps_on = 1'b1;

        configure(1'b1, 32'd500000, 32'd1500000);
        run_phase(200, 200000);

        s_axis_tvalid = 1'b0;
        for (int n = 0; n < 10000 && recs_waiting != 0; n++)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_total == 0 && recs_waiting == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
